/* rtl/mpsb_pkg.sv */
`default_nettype none
package mpsb_pkg;

  localparam int DISPLAY_WIDTH_DEF = 128;
  localparam int DISPLAY_PAGES_DEF = 8;
  localparam int ROWS_PER_PAGE     = 8;
  localparam int SPRITE_W_MAX      = 128;
  localparam int SPRITE_H_MAX      = 64;
  localparam int CMD_FIFO_DEPTH    = 4;
  localparam int STORE_AW_MAX      = 12;
  localparam int BYTE_W            = 8;
  localparam int CFG_IDX_W         = 3;

  localparam logic [1:0] FUNC_PIXEL = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MODE     = 3'd4;

  typedef struct packed {
    logic [1:0] func;
    logic       start_req;
    logic [7:0] pixel;
    logic [9:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic [9:0] byte_index;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_SET,
    OP_CLR,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [STORE_AW_MAX-1:0] addr;
    logic [7:0]              mask;
    logic                    in_range;
    logic [9:0]              index;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RMW,
    BK_RDATA,
    BK_CLEAR
  } back_state_t;

endpackage
`default_nettype wire

/* rtl/mpsb_ram.sv */
`default_nettype none
module mpsb_ram #(
  parameter int WIDTH = mpsb_pkg::BYTE_W,
  parameter int DEPTH = mpsb_pkg::DISPLAY_WIDTH_DEF * mpsb_pkg::DISPLAY_PAGES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/mpsb_fifo.sv */
`default_nettype none
module mpsb_fifo #(
  parameter int WIDTH = $bits(mpsb_pkg::cmd_t),
  parameter int DEPTH = mpsb_pkg::CMD_FIFO_DEPTH,
  localparam int PW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PW:0]      count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == (PW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/mpsb_front.sv */
`default_nettype none
module mpsb_front #(
  parameter int DISPLAY_WIDTH = mpsb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_PAGES = mpsb_pkg::DISPLAY_PAGES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_accept,
  input  wire mpsb_pkg::in_item_t                 in_item,
  input  wire logic                               cfg_write,
  input  wire logic [mpsb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [7:0]                         cfg_data,
  output logic                                    cmd_push,
  output mpsb_pkg::cmd_t                          cmd
);
  import mpsb_pkg::*;

  localparam int STORE_BYTES = DISPLAY_WIDTH * DISPLAY_PAGES;
  localparam int SCREEN_ROWS = DISPLAY_PAGES * ROWS_PER_PAGE;

  logic [7:0] width_r;
  logic [6:0] height_r;
  logic [7:0] origin_x_r, origin_y_r;
  logic       draw_mode_r;
  logic [6:0] col_r, col_nxt;
  logic [5:0] row_r, row_nxt;

  logic [6:0] col_eff;
  logic [5:0] row_eff;
  logic [7:0] w_eff, col_inc;
  logic [6:0] h_eff, row_inc;
  logic [7:0] pos_x, pos_y;
  logic       visible, lit;
  logic [STORE_AW_MAX-1:0] pix_addr;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= 8'd8;
      height_r    <= 7'd8;
      origin_x_r  <= 8'd0;
      origin_y_r  <= 8'd0;
      draw_mode_r <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SPRITE_WIDTH:  width_r     <= cfg_data;
        CFG_SPRITE_HEIGHT: height_r    <= cfg_data[6:0];
        CFG_ORIGIN_X:      origin_x_r  <= cfg_data;
        CFG_ORIGIN_Y:      origin_y_r  <= cfg_data;
        CFG_DRAW_MODE:     draw_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign col_eff = in_item.start_req ? '0 : col_r;
  assign row_eff = in_item.start_req ? '0 : row_r;

  always_comb begin
    if (width_r == '0) begin
      w_eff = 8'd1;
    end else if (width_r > 8'(SPRITE_W_MAX)) begin
      w_eff = 8'(SPRITE_W_MAX);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = 7'd1;
    end else if (height_r > 7'(SPRITE_H_MAX)) begin
      h_eff = 7'(SPRITE_H_MAX);
    end else begin
      h_eff = height_r;
    end
  end

  assign pos_x    = origin_x_r + {1'b0, col_eff};
  assign pos_y    = origin_y_r + {2'b0, row_eff};
  assign visible  = ({1'b0, pos_x} < 9'(DISPLAY_WIDTH)) && ({1'b0, pos_y} < 9'(SCREEN_ROWS));
  assign lit      = (in_item.pixel != '0);
  assign pix_addr = STORE_AW_MAX'({7'd0, pos_y[7:3]} * STORE_AW_MAX'(DISPLAY_WIDTH)
                                  + {4'd0, pos_x});

  // raster counters
  assign col_inc = {1'b0, col_eff} + 8'd1;
  assign row_inc = {1'b0, row_eff} + 7'd1;

  always_comb begin
    col_nxt = col_eff;
    row_nxt = row_eff;
    if (in_item.func == FUNC_PIXEL) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : row_inc[5:0];
      end else begin
        col_nxt = col_inc[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // classify the item into a back-end command
  always_comb begin
    cmd_push     = 1'b0;
    cmd.op       = OP_READ;
    cmd.addr     = STORE_AW_MAX'(in_item.read_index);
    cmd.mask     = 8'(1) << pos_y[2:0];
    cmd.in_range = ({3'b0, in_item.read_index} < 13'(STORE_BYTES));
    cmd.index    = in_item.read_index;
    unique case (in_item.func)
      FUNC_PIXEL: begin
        cmd.op   = draw_mode_r ? OP_SET : OP_CLR;
        cmd.addr = pix_addr;
        cmd_push = in_accept && lit && visible;
      end
      FUNC_READ: begin
        cmd_push = in_accept;
      end
      FUNC_CLEAR: begin
        cmd.op   = OP_CLEAR;
        cmd_push = in_accept;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/mpsb_back.sv */
`default_nettype none
module mpsb_back #(
  parameter int DISPLAY_WIDTH = mpsb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_PAGES = mpsb_pkg::DISPLAY_PAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mpsb_pkg::cmd_t     cmd,
  input  wire logic               cmd_empty,
  output logic                    cmd_pop,
  input  wire logic               out_pop,
  output logic                    out_empty,
  output mpsb_pkg::out_item_t     out_item,
  output logic                    init_busy
);
  import mpsb_pkg::*;

  localparam int STORE_BYTES = DISPLAY_WIDTH * DISPLAY_PAGES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  back_state_t state_r, state_nxt;
  op_t         op_r;
  logic [AW-1:0] addr_r, cnt_r;
  logic [7:0]  mask_r;
  logic        in_range_r;
  logic [9:0]  index_r;
  logic        init_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          out_take, out_free;

  assign out_take  = out_pop && out_valid_r;
  assign out_free  = !out_valid_r || out_take;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;
  assign init_busy = init_r;

  mpsb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(AW'(cmd.addr)),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          unique case (cmd.op)
            OP_SET, OP_CLR: state_nxt = BK_RMW;
            OP_READ:        state_nxt = out_free ? BK_RDATA : BK_IDLE;
            OP_CLEAR:       state_nxt = BK_CLEAR;
          endcase
        end
      end
      BK_RMW:   state_nxt = BK_IDLE;
      BK_RDATA: state_nxt = BK_IDLE;
      BK_CLEAR: state_nxt = (cnt_r == LAST_ADDR) ? BK_IDLE : BK_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = (cmd.op == OP_READ) ? out_free : 1'b1;
        end
      end
      BK_RMW: begin
        ram_we    = 1'b1;
        ram_wdata = (op_r == OP_SET) ? (ram_rdata | mask_r) : (ram_rdata & ~mask_r);
      end
      BK_RDATA: ;
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == BK_RDATA) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      cnt_r       <= '0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= (state_r == BK_CLEAR) ? cnt_r + 1'b1 : '0;
      if (state_r == BK_CLEAR && cnt_r == LAST_ADDR) begin
        init_r <= 1'b0;
      end
    end
  end

  // captured command and result payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      op_r       <= cmd.op;
      addr_r     <= AW'(cmd.addr);
      mask_r     <= cmd.mask;
      in_range_r <= cmd.in_range;
      index_r    <= cmd.index;
    end
    if (state_r == BK_RDATA) begin
      out_item_r.byte_value <= in_range_r ? ram_rdata : '0;
      out_item_r.byte_index <= index_r;
    end
  end

  a_rmw_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RMW) |-> ($past(state_r) == BK_IDLE))
    else $error("read-modify-write entered from a state other than idle");

  a_rdata_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RDATA) |-> !out_valid_r)
    else $error("read data returned while the result slot is occupied");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> ((state_r == BK_IDLE) && !cmd_empty))
    else $error("command transfer outside idle or from an empty queue");

  a_init_ends_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(init_r) |-> ($past(state_r) == BK_CLEAR))
    else $error("initial sweep ended outside the clear state");

endmodule
`default_nettype wire

/* rtl/mono_page_sprite_blitter_top.sv */
// Page-organized monochrome frame store with a streaming sprite blitter. Items enter through a
// queue-style port (push/full) and are classified at once by the front end: the sprite raster
// counters advance for every pixel item, unlit, off-screen and unused-code items end there,
// and the rest go into a four-entry command queue. The back end owns the byte store, which has
// one write port and one read port: a lit visible pixel is a read-modify-write, a byte read
// waits for room in the one-deep result register, and a clear command sweeps the store one
// byte a cycle over all DISPLAY_WIDTH*DISPLAY_PAGES bytes (1024 by default). The same sweep
// runs after reset, and full stays high until it is done. Results come out in order on the
// empty/pop side. Configuration writes are always ready and must be made while the block is idle.
`default_nettype none
module mono_page_sprite_blitter_top #(
  parameter int DISPLAY_WIDTH = mpsb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_PAGES = mpsb_pkg::DISPLAY_PAGES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire mpsb_pkg::in_item_t             in_item,
  input  wire logic                           out_pop,
  output logic                                out_empty,
  output mpsb_pkg::out_item_t                 out_item,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mpsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);
  import mpsb_pkg::*;

  logic  in_accept;
  logic  cmd_push, cmd_full, cmd_pop, cmd_empty, init_busy;
  cmd_t  cmd_in, cmd_out;

  assign cfg_ready = 1'b1;
  assign in_full   = cmd_full || init_busy;
  assign in_accept = in_push && !in_full;

  mpsb_front #(
    .DISPLAY_WIDTH(DISPLAY_WIDTH),
    .DISPLAY_PAGES(DISPLAY_PAGES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_accept(in_accept),
    .in_item  (in_item),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  mpsb_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_FIFO_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmd_push),
    .din  (cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .dout (cmd_out),
    .empty(cmd_empty)
  );

  mpsb_back #(
    .DISPLAY_WIDTH(DISPLAY_WIDTH),
    .DISPLAY_PAGES(DISPLAY_PAGES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd_out),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_item (out_item),
    .init_busy(init_busy)
  );

endmodule
`default_nettype wire
